// File: sv/sobel_edge_magnitude_rgb_macros.svh
// Assertion macros shared by the checker of the Sobel magnitude block.
// Depends on nothing; included by sem_checker.sv, which holds concurrent assertions.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// antecedent holds -> consequent in the next cycle, off while reset is high
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// same, but also checked across reset
`define SEM_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sem_pkg.sv
// Shared types and constants of the Sobel RGB gradient magnitude block.
// No dependencies; imported by all modules of the block but sem_ram.
`timescale 1ns / 1ps
package sem_pkg;
   localparam int SEM_MAX_WIDTH   = 1024;
   localparam int PIX_W           = 24;
   localparam int CHAN_W          = 8;
   localparam int CHANNELS        = 3;
   localparam int GRAD_W          = 11;
   localparam int SUM_W           = 21;
   localparam int ROW_W           = 13;
   localparam int FW_W            = 11;
   localparam int FH_W            = 12;
   localparam int CSR_DATA_W      = 12;
   localparam int SEM_QUEUE_DEPTH = 2;
   localparam logic [FW_W-1:0] FW_RESET = 11'd640;
   localparam logic [FH_W-1:0] FH_RESET = 12'd480;
   // largest sum whose rounded root still fits in eight bits
   localparam logic [SUM_W-1:0] MAG_LIMIT = 21'd65280;
   localparam logic [CHAN_W-1:0] MAG_MAX  = 8'd255;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // gradients of one output pixel, channel 0 is red
   typedef struct packed {
      logic [CHANNELS-1:0][GRAD_W-1:0] gx;
      logic [CHANNELS-1:0][GRAD_W-1:0] gy;
      logic                            last;
   } grad_type;
endpackage

// File: sv/sem_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies; holds the line buffers.
`timescale 1ns / 1ps
module sem_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/sem_front.sv
// Front end: takes pixel items, keeps counters, line buffers and the 3x3 window,
// and pushes masked Sobel gradients into the queue. Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  sem_pkg::csr_index_type              csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [sem_pkg::CHAN_W-1:0]          req_in_red,
   input  logic [sem_pkg::CHAN_W-1:0]          req_in_green,
   input  logic [sem_pkg::CHAN_W-1:0]          req_in_blue,
   output logic                                ram_wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]        ram_addr,
   output logic [2*sem_pkg::PIX_W-1:0]         ram_wr_data,
   input  logic [2*sem_pkg::PIX_W-1:0]         ram_rd_data,
   output logic                                push_valid,
   input  logic                                push_ready,
   output sem_pkg::grad_type                   push_data
);
   import sem_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > FW_W) ? WW : FW_W;

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_PRE   = 4'b0010,
      F_SHIFT = 4'b0100,
      F_EMIT  = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [FW_W-1:0]  fw_ff, fw_in;
   logic [FH_W-1:0]  fh_ff, fh_in;
   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [AW-1:0]    ocol_ff, ocol_in;
   logic [ROW_W-1:0] orow_ff, orow_in;
   logic             pre_ff, pre_in;
   logic             last_ff, last_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [2:0][2:0][PIX_W-1:0] win_ff, win_in;

   logic [CW-1:0]    fw_ext;
   logic [WW-1:0]    width_eff;
   logic [FH_W-1:0]  height_eff;
   logic [ROW_W-1:0] height_ext;
   logic             in_frame;
   logic             last_now;
   logic [2:0]       row_ok, col_ok;
   logic [AW-1:0]    col_adv;
   logic [ROW_W-1:0] row_adv;
   logic             finish;
   logic             finish_last;
   logic [CHAN_W-1:0] v [3][3];
   logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;

   // effective frame size: zero acts as one, width capped at the line buffer
   always_comb begin
      fw_ext = CW'(fw_ff);
      if (fw_ext == '0) begin
         width_eff = WW'(1);
      end else if (fw_ext > CW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(fw_ext);
      end
      height_eff = (fh_ff == '0) ? FH_W'(1) : fh_ff;
      height_ext = ROW_W'(height_eff);
      in_frame   = row_ff < height_ext;
   end

   // neighbours outside the frame count as zero
   always_comb begin
      row_ok[0] = orow_ff != '0;
      row_ok[1] = 1'b1;
      row_ok[2] = (orow_ff + ROW_W'(1)) < height_ext;
      col_ok[0] = ocol_ff != '0;
      col_ok[1] = 1'b1;
      col_ok[2] = (WW'(ocol_ff) + WW'(1)) < width_eff;
      last_now  = ((orow_ff + ROW_W'(1)) == height_ext)
                  && ((WW'(ocol_ff) + WW'(1)) == width_eff);
   end

   always_comb begin
      push_data.last = last_now;
      push_data.gx   = '0;
      push_data.gy   = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               v[r][c] = (row_ok[r] && col_ok[c])
                         ? win_ff[r][c][(CHANNELS-1-ch)*CHAN_W +: CHAN_W] : '0;
            end
         end
         gx_pos = GRAD_W'(v[0][2]) + GRAD_W'({v[1][2], 1'b0}) + GRAD_W'(v[2][2]);
         gx_neg = GRAD_W'(v[0][0]) + GRAD_W'({v[1][0], 1'b0}) + GRAD_W'(v[2][0]);
         gy_pos = GRAD_W'(v[2][0]) + GRAD_W'({v[2][1], 1'b0}) + GRAD_W'(v[2][2]);
         gy_neg = GRAD_W'(v[0][0]) + GRAD_W'({v[0][1], 1'b0}) + GRAD_W'(v[0][2]);
         push_data.gx[ch] = gx_pos - gx_neg;
         push_data.gy[ch] = gy_pos - gy_neg;
      end
   end

   always_comb begin
      if ((WW'(col_ff) + WW'(1)) >= width_eff) begin
         col_adv = '0;
         row_adv = row_ff + ROW_W'(1);
      end else begin
         col_adv = col_ff + AW'(1);
         row_adv = row_ff;
      end
   end

   assign req_ready   = state_ff == F_IDLE;
   assign push_valid  = state_ff == F_EMIT;
   assign ram_addr    = col_ff;
   assign ram_wr_en   = state_ff == F_SHIFT;
   assign ram_wr_data = {ram_rd_data[PIX_W-1:0], pix_ff};

   always_comb begin
      state_in    = state_ff;
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      ocol_in     = ocol_ff;
      orow_in     = orow_ff;
      pre_in      = pre_ff;
      last_in     = last_ff;
      pix_in      = pix_ff;
      win_in      = win_ff;
      finish      = 1'b0;
      finish_last = last_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && !(req_type && in_frame)) begin
               pix_in  = in_frame ? {req_in_red, req_in_green, req_in_blue} : '0;
               last_in = 1'b0;
               state_in = (col_ff == '0 && row_ff >= ROW_W'(2)) ? F_PRE : F_SHIFT;
            end
         end
         F_PRE: begin
            // right edge of the row two up: close the window with a zero column
            for (int r = 0; r < 3; r++) begin
               win_in[r] = {PIX_W'(0), win_ff[r][2], win_ff[r][1]};
            end
            orow_in  = row_ff - ROW_W'(2);
            ocol_in  = AW'(width_eff - WW'(1));
            pre_in   = 1'b1;
            state_in = F_EMIT;
         end
         F_SHIFT: begin
            win_in[0] = {ram_rd_data[2*PIX_W-1:PIX_W], win_ff[0][2], win_ff[0][1]};
            win_in[1] = {ram_rd_data[PIX_W-1:0], win_ff[1][2], win_ff[1][1]};
            win_in[2] = {pix_ff, win_ff[2][2], win_ff[2][1]};
            if (col_ff != '0 && row_ff != '0) begin
               orow_in  = row_ff - ROW_W'(1);
               ocol_in  = col_ff - AW'(1);
               pre_in   = 1'b0;
               state_in = F_EMIT;
            end else begin
               finish   = 1'b1;
               state_in = F_IDLE;
            end
         end
         F_EMIT: begin
            if (push_ready) begin
               last_in = last_now;
               if (pre_ff) begin
                  state_in = F_SHIFT;
               end else begin
                  finish      = 1'b1;
                  finish_last = last_now;
                  state_in    = F_IDLE;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      if (finish) begin
         col_in = finish_last ? '0 : col_adv;
         row_in = finish_last ? '0 : row_adv;
      end
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:  fw_in = csr_wdata[FW_W-1:0];
            REG_FRAME_HEIGHT: fh_in = csr_wdata[FH_W-1:0];
            default: begin
               fw_in = fw_ff;
            end
         endcase
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         fw_ff    <= FW_RESET;
         fh_ff    <= FH_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fw_ff    <= fw_in;
         fh_ff    <= fh_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         win_ff   <= win_in;
      end
      ocol_ff <= ocol_in;
      orow_ff <= orow_in;
      pre_ff  <= pre_in;
      last_ff <= last_in;
      pix_ff  <= pix_in;
   end
endmodule

// File: sv/sem_queue.sv
// Short item queue between the front end and the magnitude unit.
// Depends on sem_pkg for the entry type.
`timescale 1ns / 1ps
module sem_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  sem_pkg::grad_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output sem_pkg::grad_type pop_data
);
   import sem_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   grad_type      mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != NW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + NW'(do_push) - NW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: sv/sem_back.sv
// Back end: squares the gradients, takes a rounded square root bit by bit
// for all three channels, and holds the result item. Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  sem_pkg::grad_type          pop_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [sem_pkg::CHAN_W-1:0] rsp_out_red,
   output logic [sem_pkg::CHAN_W-1:0] rsp_out_green,
   output logic [sem_pkg::CHAN_W-1:0] rsp_out_blue,
   output logic                       rsp_frame_last
);
   import sem_pkg::*;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_SQX  = 5'b00010,
      B_SQY  = 5'b00100,
      B_ROOT = 5'b01000,
      B_DONE = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;
   grad_type       item_ff, item_in;
   logic [2:0]     iter_ff, iter_in;
   logic [CHANNELS-1:0][SUM_W-1:0]  sum_ff, sum_in;
   logic [CHANNELS-1:0]             clamp_ff, clamp_in;
   logic [CHANNELS-1:0][15:0]       src_ff, src_in;
   logic [CHANNELS-1:0][9:0]        rem_ff, rem_in;
   logic [CHANNELS-1:0][CHAN_W-1:0] root_ff, root_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [CHANNELS-1:0][CHAN_W-1:0] res_ff, res_in;
   logic                            res_last_ff, res_last_in;

   logic [2*GRAD_W-1:0] sq;
   logic [SUM_W-1:0]    total;
   logic [11:0]         rem_x, trial;
   logic                load_out;

   assign pop_ready = state_ff == B_IDLE;
   assign load_out  = (state_ff == B_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      iter_in      = iter_ff;
      sum_in       = sum_ff;
      clamp_in     = clamp_ff;
      src_in       = src_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      res_in       = res_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sq    = '0;
      total = '0;
      rem_x = '0;
      trial = '0;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               item_in  = pop_data;
               state_in = B_SQX;
            end
         end
         B_SQX: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               sq = $signed(item_ff.gx[ch]) * $signed(item_ff.gx[ch]);
               sum_in[ch] = sq[SUM_W-1:0];
            end
            state_in = B_SQY;
         end
         B_SQY: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               sq = $signed(item_ff.gy[ch]) * $signed(item_ff.gy[ch]);
               total = sum_ff[ch] + sq[SUM_W-1:0];
               sum_in[ch]   = total;
               clamp_in[ch] = total > MAG_LIMIT;
               src_in[ch]   = total[15:0];
            end
            rem_in   = '0;
            root_in  = '0;
            iter_in  = '0;
            state_in = B_ROOT;
         end
         B_ROOT: begin
            // one root bit per cycle, two bits of the sum brought down
            for (int ch = 0; ch < CHANNELS; ch++) begin
               rem_x = {rem_ff[ch], src_ff[ch][15:14]};
               trial = {2'b00, root_ff[ch], 2'b01};
               if (rem_x >= trial) begin
                  rem_in[ch]  = 10'(rem_x - trial);
                  root_in[ch] = {root_ff[ch][CHAN_W-2:0], 1'b1};
               end else begin
                  rem_in[ch]  = rem_x[9:0];
                  root_in[ch] = {root_ff[ch][CHAN_W-2:0], 1'b0};
               end
               src_in[ch] = {src_ff[ch][13:0], 2'b00};
            end
            iter_in = iter_ff + 3'd1;
            if (iter_ff == 3'd7) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (load_out) begin
               // remainder above the root means the sum passed r*r + r
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  if (clamp_ff[ch]) begin
                     res_in[ch] = MAG_MAX;
                  end else if (rem_ff[ch] > {2'b00, root_ff[ch]}) begin
                     res_in[ch] = root_ff[ch] + CHAN_W'(1);
                  end else begin
                     res_in[ch] = root_ff[ch];
                  end
               end
               res_last_in  = item_ff.last;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      iter_ff     <= iter_in;
      sum_ff      <= sum_in;
      clamp_ff    <= clamp_in;
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      res_ff      <= res_in;
      res_last_ff <= res_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = res_ff[0];
   assign rsp_out_green  = res_ff[1];
   assign rsp_out_blue   = res_ff[2];
   assign rsp_frame_last = res_last_ff;
endmodule

// File: sv/sobel_edge_magnitude_rgb.sv
// Sobel 3x3 gradient magnitude on an RGB pixel stream, zero border, per channel
// round(sqrt(gx^2 + gy^2)) clamped to 255. Output pixel k of a frame comes with
// input item k + W + 1; after the last pixel send W + 1 drain items (req_type = 1)
// to flush the tail, and rsp_frame_last marks the frame's final result. Any csr
// write restarts the frame. The front end takes an item through accept, line
// buffer read and window shift, and gradient push, with a window close and push
// first at a row start; a drain ignored inside the frame is only accepted. The
// magnitude unit works on one item at a time: squaring in B_SQX and B_SQY, then
// its bit-serial square root (8 steps); it takes a new item once the result is
// loaded. A two-entry queue lets the front run ahead. Line buffers need no
// clearing after reset; the block takes items as soon as reset is released.
// Depends on sem_pkg, sem_ram, sem_front, sem_queue, sem_back.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  sem_pkg::csr_index_type         csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic [sem_pkg::CHAN_W-1:0]     req_in_red,
   input  logic [sem_pkg::CHAN_W-1:0]     req_in_green,
   input  logic [sem_pkg::CHAN_W-1:0]     req_in_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sem_pkg::CHAN_W-1:0]     rsp_out_red,
   output logic [sem_pkg::CHAN_W-1:0]     rsp_out_green,
   output logic [sem_pkg::CHAN_W-1:0]     rsp_out_blue,
   output logic                           rsp_frame_last
);
   import sem_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_addr;
   logic [2*PIX_W-1:0]   ram_wr_data, ram_rd_data;
   logic                 push_valid, push_ready, pop_valid, pop_ready;
   grad_type             push_data, pop_data;

   // upper line in the high half, middle line in the low half
   sem_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   sem_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .ram_wr_en    (ram_wr_en),
      .ram_addr     (ram_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_data  (ram_rd_data),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   sem_queue #(
      .DEPTH (SEM_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sem_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last)
   );
endmodule

// File: sv/sem_checker.sv
// Port-level checks for the Sobel magnitude block, bound to its top level.
// Depends on sem_pkg and sobel_edge_magnitude_rgb_macros.svh.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_macros.svh"
module sem_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sem_pkg::CHAN_W-1:0]     rsp_out_red,
   input logic [sem_pkg::CHAN_W-1:0]     rsp_out_green,
   input logic [sem_pkg::CHAN_W-1:0]     rsp_out_blue,
   input logic                           rsp_frame_last
);
   import sem_pkg::*;

   logic                  rsp_take;
   logic [3*CHAN_W:0]     rsp_payload;

   assign rsp_take    = rsp_valid && rsp_ready;
   assign rsp_payload = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_last};

   // a stalled result item stays offered
   `SEM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped")

   // and keeps its payload
   `SEM_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload), "rsp changed")

   // reset empties the result register and opens the input
   `SEM_ASSERT_NEXT_ALWAYS(a_reset_state, reset, !rsp_valid && req_ready, "bad reset state")

   // the root unit cannot deliver result items back to back: after two takes in a row, no item is offered
   `SEM_ASSERT_NEXT(a_root_spacing, rsp_take ##1 rsp_take, !rsp_valid, "results too close")
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);
